// File: src/rpf_pkg.sv
// Package: shared constants, codes and types of the record predicate filter.
package rpf_pkg;

  localparam int PageBytesDefault = 4096;
  localparam int KeyBytesDefault  = 32;
  localparam int PosW             = 13;
  localparam logic [PosW-1:0] PosMax = 13'd8191;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_FLOAT = 2'd1,
    KIND_STR   = 2'd2,
    KIND_STR3  = 2'd3
  } attr_kind_t;

  typedef enum logic [2:0] {
    REL_NONE = 3'd0,
    REL_EQ   = 3'd1,
    REL_NE   = 3'd2,
    REL_LT   = 3'd3,
    REL_GT   = 3'd4,
    REL_LE   = 3'd5,
    REL_GE   = 3'd6,
    REL_ANY  = 3'd7
  } relation_t;

  typedef enum logic [1:0] {
    ORD_UNDECIDED = 2'd0,
    ORD_LESS      = 2'd1,
    ORD_GREATER   = 2'd2,
    ORD_UNUSED    = 2'd3
  } str_order_t;

  localparam logic [2:0] CFG_KIND   = 3'd0;
  localparam logic [2:0] CFG_REL    = 3'd1;
  localparam logic [2:0] CFG_OFFSET = 3'd2;
  localparam logic [2:0] CFG_LENGTH = 3'd3;
  localparam logic [2:0] CFG_KEY_A  = 3'd4;
  localparam logic [2:0] CFG_KEY_B  = 3'd5;
  localparam logic [2:0] CFG_KEY_C  = 3'd6;
  localparam logic [2:0] CFG_KEY_D  = 3'd7;

  // Compare result codes
  typedef struct packed {
    logic lt;
    logic gt;
    logic eq;
  } cmp_t;

endpackage

// File: src/rpf_verdict.sv
// Verdict logic: numeric/string compare outcome and relation check.
module rpf_verdict
  import rpf_pkg::*;
(
  input  logic [1:0]  attr_kind,
  input  logic [2:0]  relation,
  input  logic [31:0] capture,
  input  logic [31:0] key,
  input  logic [1:0]  order,
  output logic        pass
);

  cmp_t c;
  logic [31:0] ia, ib;
  logic a_nan, b_nan, a_zero, b_zero, sa, sb;
  logic mag_lt, mag_gt;

  always_comb begin
    // integer: bias sign bit then compare unsigned
    ia = capture ^ 32'h8000_0000;
    ib = key ^ 32'h8000_0000;
    a_nan = (capture[30:23] == 8'hFF) && (capture[22:0] != 23'd0);
    b_nan = (key[30:23] == 8'hFF) && (key[22:0] != 23'd0);
    a_zero = (capture[30:0] == 31'd0);
    b_zero = (key[30:0] == 31'd0);
    sa = capture[31];
    sb = key[31];
    mag_lt = capture[30:0] < key[30:0];
    mag_gt = capture[30:0] > key[30:0];
    c = '0;
    case (attr_kind)
      KIND_INT: begin
        c.lt = ia < ib;
        c.gt = ia > ib;
        c.eq = ia == ib;
      end
      KIND_FLOAT: begin
        if (a_nan || b_nan) begin
          c = '0;
        end else if (a_zero && b_zero) begin
          c.eq = 1'b1;
        end else if (sa != sb) begin
          c.lt = sa;
          c.gt = sb;
        end else begin
          c.eq = capture[30:0] == key[30:0];
          c.lt = sa ? mag_gt : mag_lt;
          c.gt = sa ? mag_lt : mag_gt;
        end
      end
      default: begin
        c.lt = order == ORD_LESS;
        c.gt = order == ORD_GREATER;
        c.eq = !(c.lt || c.gt);
      end
    endcase
    // apply relation
    case (relation)
      REL_EQ:  pass = c.eq;
      REL_NE:  pass = !c.eq;
      REL_LT:  pass = c.lt;
      REL_GT:  pass = c.gt;
      REL_LE:  pass = c.lt || c.eq;
      REL_GE:  pass = c.gt || c.eq;
      default: pass = 1'b1;
    endcase
  end

endmodule

// File: src/record_predicate_filter_unit.sv
// Top level: record predicate filter with byte stream input and one verdict per record.
//
// Takes one record byte per cycle unless in_stall is high; the byte is registered,
// folded into the running attribute state in the next cycle, and on the record's last
// byte a verdict beat is written to the result queue in that same cycle. Sustained rate
// is one byte per cycle, set by the single registered pass between the input register
// and the result register; a two-entry result queue absorbs a stalled output, and the
// input stalls only once a verdict would have no free entry.
module record_predicate_filter_unit
  import rpf_pkg::*;
#(
  parameter int KEY_BYTES = KeyBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rec_byte,
  input  logic        end_of_record,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        match,
  output logic        attr_incomplete
);

  logic [1:0]  attr_kind;
  logic [2:0]  relation;
  logic [11:0] field_offset;
  logic [5:0]  field_length;
  logic [63:0] key_word [4];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attr_kind <= KIND_INT;
      relation <= REL_NONE;
      field_offset <= '0;
      field_length <= 6'd4;
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KIND:   attr_kind <= cfg_data[1:0];
        CFG_REL:    relation <= cfg_data[2:0];
        CFG_OFFSET: field_offset <= cfg_data[11:0];
        CFG_LENGTH: field_length <= cfg_data[5:0];
        CFG_KEY_A:  key_word[0] <= cfg_data;
        CFG_KEY_B:  key_word[1] <= cfg_data;
        CFG_KEY_C:  key_word[2] <= cfg_data;
        CFG_KEY_D:  key_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic       in_reg_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       in_take;
  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) in_reg_valid <= 1'b0;
    else     in_reg_valid <= in_take;
    if (in_take) begin
      in_byte <= rec_byte;
      in_last <= end_of_record;
    end
  end

  // record state
  logic [PosW-1:0] byte_position, byte_position_next;
  logic [31:0]     numeric_capture, numeric_capture_next;
  logic [1:0]      string_order, string_order_next;
  logic            string_stopped, string_stopped_next;

  logic            numeric;
  logic [5:0]      len;
  logic [PosW-1:0] fend;
  logic [PosW-1:0] k;
  logic [7:0]      kb;
  logic            in_attr;
  logic            done_incomplete;
  logic [31:0]     cap_final;
  logic [1:0]      ord_final;
  logic            pass;

  always_comb begin
    numeric = (attr_kind == KIND_INT) || (attr_kind == KIND_FLOAT);
    if (numeric) len = 6'd4;
    else if (field_length > 6'(KEY_BYTES)) len = 6'(KEY_BYTES);
    else len = field_length;
    fend = PosW'(field_offset) + PosW'(len);
    in_attr = (byte_position >= PosW'(field_offset)) && (byte_position < fend);
    k = byte_position - PosW'(field_offset);
    kb = key_word[k[4:3]][{k[2:0], 3'b000} +: 8];
    numeric_capture_next = numeric_capture;
    string_order_next = string_order;
    string_stopped_next = string_stopped;
    if (in_attr) begin
      if (numeric) begin
        numeric_capture_next = numeric_capture | (32'(in_byte) << {k[1:0], 3'b000});
      end else if (string_order == ORD_UNDECIDED && !string_stopped) begin
        if (in_byte < kb) string_order_next = ORD_LESS;
        else if (in_byte > kb) string_order_next = ORD_GREATER;
        else if (in_byte == 8'd0) string_stopped_next = 1'b1;
      end
    end
    byte_position_next = (byte_position < PosMax) ? byte_position + 1'b1 : byte_position;
    done_incomplete = byte_position_next < fend;
    cap_final = numeric_capture_next;
    ord_final = string_order_next;
  end

  rpf_verdict u_verdict (
    .attr_kind (attr_kind),
    .relation  (relation),
    .capture   (cap_final),
    .key       (key_word[0][31:0]),
    .order     (ord_final),
    .pass      (pass)
  );

  // advance state; clear after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      numeric_capture <= '0;
      string_order <= ORD_UNDECIDED;
      string_stopped <= 1'b0;
    end else if (in_reg_valid) begin
      if (in_last) begin
        byte_position <= '0;
        numeric_capture <= '0;
        string_order <= ORD_UNDECIDED;
        string_stopped <= 1'b0;
      end else begin
        byte_position <= byte_position_next;
        numeric_capture <= numeric_capture_next;
        string_order <= string_order_next;
        string_stopped <= string_stopped_next;
      end
    end
  end

  // result skid: two entries so one in flight always has room
  logic       res_push;
  logic       res_pop;
  logic [1:0] res_count;
  logic [1:0] res_data [2];
  logic       res_rd, res_wr;

  assign res_push = in_reg_valid && in_last;
  assign res_pop = out_valid && !out_stall;
  assign out_valid = res_count != 2'd0;
  assign {match, attr_incomplete} = res_data[res_rd];
  // hold input when the queue could overflow with the beat already in flight
  assign in_stall = (res_count == 2'd2) ||
                    (res_count == 2'd1 && in_reg_valid && in_last && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= '0;
      res_rd <= 1'b0;
      res_wr <= 1'b0;
    end else begin
      if (res_push) res_wr <= !res_wr;
      if (res_pop) res_rd <= !res_rd;
      res_count <= res_count + {1'b0, res_push} - {1'b0, res_pop};
    end
    if (res_push) res_data[res_wr] <= {!done_incomplete && pass, done_incomplete};
  end

endmodule
